/* rtl/core/slc_pkg.sv */
package slc_pkg;

    localparam int ACTION_WIDTH = 2;
    localparam int CLASS_WIDTH  = 3;
    localparam int BYTE_WIDTH   = 8;
    localparam int FIELD_WIDTH  = 32;

    // Item kinds carried on the input side.
    localparam logic [ACTION_WIDTH-1:0] ACT_CHAR = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_EOL  = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_FILE = 2'd2;

    // Line classes reported on the output side.
    localparam logic [CLASS_WIDTH-1:0] CLS_NONE    = 3'd0;
    localparam logic [CLASS_WIDTH-1:0] CLS_BLANK   = 3'd1;
    localparam logic [CLASS_WIDTH-1:0] CLS_COMMENT = 3'd2;
    localparam logic [CLASS_WIDTH-1:0] CLS_CODE    = 3'd3;
    localparam logic [CLASS_WIDTH-1:0] CLS_WHITE   = 3'd4;

    localparam logic [BYTE_WIDTH-1:0] CHR_QUOTE = 8'h22;
    localparam logic [BYTE_WIDTH-1:0] CHR_SLASH = 8'h2F;
    localparam logic [BYTE_WIDTH-1:0] CHR_STAR  = 8'h2A;
    localparam logic [BYTE_WIDTH-1:0] CHR_SPACE = 8'h20;
    localparam logic [BYTE_WIDTH-1:0] CHR_TAB   = 8'h09;
    localparam logic [BYTE_WIDTH-1:0] CHR_CR    = 8'h0D;

    // Counter update request from the line tracker to the counters.
    typedef struct packed {
        logic clear;
        logic code;
        logic comment;
        logic blank;
    } t_bump;

    function automatic logic is_ws(input logic [BYTE_WIDTH-1:0] c);
        return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
    endfunction

endpackage

/* rtl/core/slc_line_tracker.sv */
module slc_line_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic [slc_pkg::ACTION_WIDTH-1:0] i_action,
    input  logic [slc_pkg::BYTE_WIDTH-1:0]   i_byte,
    output logic [slc_pkg::CLASS_WIDTH-1:0]  o_class,
    output slc_pkg::t_bump                   o_bump
);
    import slc_pkg::*;

    logic                  r_ibc, r_iqs, r_code, r_comment, r_nonempty, r_skip, r_hvalid;
    logic [BYTE_WIDTH-1:0] r_held;
    logic                  n_ibc, n_iqs, n_code, n_comment, n_nonempty, n_skip, n_hvalid;
    logic [BYTE_WIDTH-1:0] n_held;
    logic                  f_code, f_comment;

    always_comb begin
        n_ibc      = r_ibc;
        n_iqs      = r_iqs;
        n_code     = r_code;
        n_comment  = r_comment;
        n_nonempty = r_nonempty;
        n_skip     = r_skip;
        n_hvalid   = r_hvalid;
        n_held     = r_held;
        f_code     = r_code;
        f_comment  = r_comment;
        o_class    = CLS_NONE;
        o_bump     = '0;
        unique case (i_action)
            ACT_CHAR: begin
                n_nonempty = 1'b1;
                if (!r_skip && !r_hvalid) begin
                    n_held   = i_byte;
                    n_hvalid = 1'b1;
                end else if (!r_skip) begin
                    // Judge the held character with the new byte as lookahead.
                    n_held = i_byte;
                    if (r_held == CHR_QUOTE && !r_ibc) begin
                        n_iqs  = !r_iqs;
                        n_code = 1'b1;
                    end
                    if (r_ibc) begin
                        n_comment = 1'b1;
                        if (r_held == CHR_STAR && i_byte == CHR_SLASH) begin
                            n_ibc    = 1'b0;
                            n_hvalid = 1'b0;
                            n_held   = '0;
                        end
                    end else if (is_ws(r_held)) begin
                        n_hvalid = 1'b1;
                    end else if (r_held == CHR_SLASH && i_byte == CHR_SLASH && !r_iqs) begin
                        n_comment = 1'b1;
                        n_skip    = 1'b1;
                        n_hvalid  = 1'b0;
                        n_held    = '0;
                    end else if (r_held == CHR_SLASH && i_byte == CHR_STAR && !r_iqs) begin
                        n_ibc     = 1'b1;
                        n_comment = 1'b1;
                        n_hvalid  = 1'b0;
                        n_held    = '0;
                    end else begin
                        n_code = 1'b1;
                    end
                end
            end
            ACT_EOL: begin
                // The held character has no successor here.
                if (r_hvalid && !r_skip) begin
                    if (r_ibc) begin
                        f_comment = 1'b1;
                    end else if (!is_ws(r_held)) begin
                        f_code = 1'b1;
                    end
                end
                if (!r_nonempty) begin
                    if (r_ibc) begin
                        o_class        = CLS_COMMENT;
                        o_bump.comment = 1'b1;
                    end else begin
                        o_class      = CLS_BLANK;
                        o_bump.blank = 1'b1;
                    end
                end else if (f_code) begin
                    o_class     = CLS_CODE;
                    o_bump.code = 1'b1;
                end else if (f_comment) begin
                    o_class        = CLS_COMMENT;
                    o_bump.comment = 1'b1;
                end else begin
                    o_class = CLS_WHITE;
                end
                n_iqs      = 1'b0;
                n_code     = 1'b0;
                n_comment  = 1'b0;
                n_nonempty = 1'b0;
                n_skip     = 1'b0;
                n_hvalid   = 1'b0;
                n_held     = '0;
            end
            ACT_FILE: begin
                n_ibc        = 1'b0;
                n_iqs        = 1'b0;
                n_code       = 1'b0;
                n_comment    = 1'b0;
                n_nonempty   = 1'b0;
                n_skip       = 1'b0;
                n_hvalid     = 1'b0;
                n_held       = '0;
                o_bump.clear = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ibc      <= 1'b0;
            r_iqs      <= 1'b0;
            r_code     <= 1'b0;
            r_comment  <= 1'b0;
            r_nonempty <= 1'b0;
            r_skip     <= 1'b0;
            r_hvalid   <= 1'b0;
            r_held     <= '0;
        end else if (i_en) begin
            r_ibc      <= n_ibc;
            r_iqs      <= n_iqs;
            r_code     <= n_code;
            r_comment  <= n_comment;
            r_nonempty <= n_nonempty;
            r_skip     <= n_skip;
            r_hvalid   <= n_hvalid;
            r_held     <= n_held;
        end
    end

endmodule

/* rtl/core/slc_counters.sv */
module slc_counters #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  slc_pkg::t_bump         i_bump,
    output logic [COUNT_WIDTH-1:0] o_code,
    output logic [COUNT_WIDTH-1:0] o_comment,
    output logic [COUNT_WIDTH-1:0] o_blank
);
    import slc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    logic [COUNT_WIDTH-1:0] r_code, r_comment, r_blank;

    // Next values; they are also the counts reported with this item.
    always_comb begin
        o_code    = r_code;
        o_comment = r_comment;
        o_blank   = r_blank;
        if (i_bump.clear) begin
            o_code    = '0;
            o_comment = '0;
            o_blank   = '0;
        end else begin
            if (i_bump.code && r_code != COUNT_MAX) begin
                o_code = r_code + COUNT_ONE;
            end
            if (i_bump.comment && r_comment != COUNT_MAX) begin
                o_comment = r_comment + COUNT_ONE;
            end
            if (i_bump.blank && r_blank != COUNT_MAX) begin
                o_blank = r_blank + COUNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code    <= '0;
            r_comment <= '0;
            r_blank   <= '0;
        end else if (i_en) begin
            r_code    <= o_code;
            r_comment <= o_comment;
            r_blank   <= o_blank;
        end
    end

endmodule

/* rtl/core/source_line_classifier.sv */
// An accepted item waits in the input register and is written into the result register,
//   which offers its result, once that register is free or being drained.
// Throughput: one item per cycle; while a result waits, the input register takes one
//   more item and the input side then stalls until the result is taken.
//   The per-character state update and the counter increment happen at the same edge.
// Reset: synchronous, active low; clears line state, lookahead, counters and valids.
module source_line_classifier #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_byte
    input  logic [1:0]   s_axis_tuser,   // [1:0] action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // [31:0] code_count, [63:32] comment_count,
                                         // [95:64] blank_count
    output logic [2:0]   m_axis_tuser    // [2:0] line_class
);
    import slc_pkg::*;

    // Input register stage.
    logic                    r_in_valid;
    logic [ACTION_WIDTH-1:0] r_action;
    logic [BYTE_WIDTH-1:0]   r_byte;

    // Result register stage.
    logic                    r_out_valid;
    logic [CLASS_WIDTH-1:0]  r_class;
    logic [FIELD_WIDTH-1:0]  r_code, r_comment, r_blank;

    logic                    advance;
    logic [CLASS_WIDTH-1:0]  line_class;
    t_bump                   bump;
    logic [COUNT_WIDTH-1:0]  cnt_code, cnt_comment, cnt_blank;
    logic [FIELD_WIDTH-1:0]  fld_code, fld_comment, fld_blank;

    // The held item moves into the result register when that register is free
    // or being drained; the state of the line tracker updates at the same edge.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    slc_line_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_action (r_action),
        .i_byte   (r_byte),
        .o_class  (line_class),
        .o_bump   (bump)
    );

    slc_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_bump    (bump),
        .o_code    (cnt_code),
        .o_comment (cnt_comment),
        .o_blank   (cnt_blank)
    );

    // The reported counts are the low 32 bits of the counters, zero-extended if narrower.
    generate
        if (COUNT_WIDTH >= FIELD_WIDTH) begin : g_trunc
            assign fld_code    = cnt_code[FIELD_WIDTH-1:0];
            assign fld_comment = cnt_comment[FIELD_WIDTH-1:0];
            assign fld_blank   = cnt_blank[FIELD_WIDTH-1:0];
        end else begin : g_extend
            assign fld_code    = {{(FIELD_WIDTH-COUNT_WIDTH){1'b0}}, cnt_code};
            assign fld_comment = {{(FIELD_WIDTH-COUNT_WIDTH){1'b0}}, cnt_comment};
            assign fld_blank   = {{(FIELD_WIDTH-COUNT_WIDTH){1'b0}}, cnt_blank};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action <= s_axis_tuser;
            r_byte   <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_class   <= line_class;
            r_code    <= fld_code;
            r_comment <= fld_comment;
            r_blank   <= fld_blank;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_class;
    assign m_axis_tdata  = {r_blank, r_comment, r_code};

endmodule

/* dv/source_line_classifier_test.sv */
`timescale 1ns / 1ps

module source_line_classifier_test;

    import slc_pkg::*;

    // The package names the three real item kinds; code 3 is ignored by the block
    // but still has to be exercised.
    localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

    localparam int  TOTAL_ITEMS  = 475;
    localparam int  STEADY_FIRST = 170;
    localparam int  STEADY_LAST  = 280;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam time HALF_PERIOD  = 6ns;

    // One output item as the block presents it.
    typedef struct packed {
        logic [CLASS_WIDTH-1:0] line_class;
        logic [FIELD_WIDTH-1:0] code_count;
        logic [FIELD_WIDTH-1:0] comment_count;
        logic [FIELD_WIDTH-1:0] blank_count;
    } t_line_tally;

    // Line-classification predictor plus the queue of tallies still owed by the block.
    class t_tally_board;
        bit                     in_block;
        bit                     in_quote;
        bit                     has_code;
        bit                     has_comment;
        bit                     nonempty;
        bit                     skip_line;
        bit                     held_valid;
        logic [BYTE_WIDTH-1:0]  held;
        logic [FIELD_WIDTH-1:0] code_total;
        logic [FIELD_WIDTH-1:0] comment_total;
        logic [FIELD_WIDTH-1:0] blank_total;
        t_line_tally            owed_q[$];
        int                     errors;
        int                     class_seen[5];

        function new();
            restart();
        endfunction

        function void restart();
            in_block      = 0;
            in_quote      = 0;
            has_code      = 0;
            has_comment   = 0;
            nonempty      = 0;
            skip_line     = 0;
            held_valid    = 0;
            held          = '0;
            code_total    = '0;
            comment_total = '0;
            blank_total   = '0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Decides the held character once its successor (or the line end) is known.
        // Returns 1 when the successor was swallowed as the second half of a mark.
        function bit judge(logic [BYTE_WIDTH-1:0] c, bit has_next,
                           logic [BYTE_WIDTH-1:0] nx);
            if (c == CHR_QUOTE && !in_block) begin
                in_quote = !in_quote;
                has_code = 1;
            end
            if (in_block) begin
                has_comment = 1;
                if (has_next && c == CHR_STAR && nx == CHR_SLASH) begin
                    in_block = 0;
                    return 1;
                end
                return 0;
            end
            if (c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR))
                return 0;
            if (has_next && c == CHR_SLASH && !in_quote) begin
                if (nx == CHR_SLASH) begin
                    has_comment = 1;
                    skip_line   = 1;
                    return 1;
                end
                if (nx == CHR_STAR) begin
                    in_block    = 1;
                    has_comment = 1;
                    return 1;
                end
            end
            has_code = 1;
            return 0;
        endfunction

        function void note_item(logic [ACTION_WIDTH-1:0] action, logic [BYTE_WIDTH-1:0] ch);
            t_line_tally tally;
            tally.line_class = CLS_NONE;
            case (action)
                ACT_CHAR: begin
                    nonempty = 1;
                    if (!skip_line) begin
                        if (held_valid) begin
                            if (judge(held, 1, ch) || skip_line)
                                held_valid = 0;
                            else
                                held = ch;
                        end else begin
                            held       = ch;
                            held_valid = 1;
                        end
                    end
                end
                ACT_EOL: begin
                    if (held_valid && !skip_line)
                        void'(judge(held, 0, '0));
                    if (!nonempty) begin
                        if (in_block) begin
                            tally.line_class = CLS_COMMENT;
                            if (comment_total != '1) comment_total++;
                        end else begin
                            tally.line_class = CLS_BLANK;
                            if (blank_total != '1) blank_total++;
                        end
                    end else if (has_code) begin
                        tally.line_class = CLS_CODE;
                        if (code_total != '1) code_total++;
                    end else if (has_comment) begin
                        tally.line_class = CLS_COMMENT;
                        if (comment_total != '1) comment_total++;
                    end else begin
                        tally.line_class = CLS_WHITE;
                    end
                    in_quote    = 0;
                    has_code    = 0;
                    has_comment = 0;
                    nonempty    = 0;
                    skip_line   = 0;
                    held_valid  = 0;
                    held        = '0;
                end
                ACT_FILE: begin
                    restart();
                end
                default: begin
                end
            endcase
            tally.code_count    = code_total;
            tally.comment_count = comment_total;
            tally.blank_count   = blank_total;
            class_seen[tally.line_class]++;
            owed_q.push_back(tally);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_line_tally got);
            t_line_tally want;
            if (owed_q.size() == 0) begin
                report($sformatf("result with nothing outstanding (class %0d)",
                                 got.line_class));
                return;
            end
            want = owed_q.pop_front();
            if (got.line_class != want.line_class)
                report($sformatf("line_class got %0d want %0d",
                                 got.line_class, want.line_class));
            if (got.code_count != want.code_count)
                report($sformatf("code_count got %0d want %0d",
                                 got.code_count, want.code_count));
            if (got.comment_count != want.comment_count)
                report($sformatf("comment_count got %0d want %0d",
                                 got.comment_count, want.comment_count));
            if (got.blank_count != want.blank_count)
                report($sformatf("blank_count got %0d want %0d",
                                 got.blank_count, want.blank_count));
        endtask
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata  = '0;    // [7:0] char_byte
    logic [1:0]              s_axis_tuser  = '0;    // [1:0] action
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [95:0]             m_axis_tdata;          // [31:0] code, [63:32] comment,
                                                    // [95:64] blank
    logic [2:0]              m_axis_tuser;          // [2:0] line_class

    t_tally_board board = new();

    // While this is set neither side inserts idle cycles, so the block sees a
    // long back-to-back stretch in the middle of the random phase.
    bit steady      = 1'b0;
    int sent        = 0;
    int ignored     = 0;
    int file_starts = 0;
    int cycles      = 0;

    source_line_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    // Output side: random back-pressure, and every accepted result is checked
    // against the oldest outstanding prediction. Values read here are the ones
    // that were present just before the edge.
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 33);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result({m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                                m_axis_tdata[95:64]});
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, board.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one item, possibly after a few random idle cycles, and returns at the
    // edge where it was taken. The prediction is made at that same edge.
    task send_item(input logic [1:0] action, input logic [7:0] ch);
        while (!steady && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= ch;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.note_item(action, ch);
        if (action == ACT_UNUSED)
            ignored++;
        else
            sent++;
        if (action == ACT_FILE)
            file_starts++;
        steady = (sent >= STEADY_FIRST) && (sent < STEADY_LAST);
    endtask

    // Holds the input side quiet until the block has delivered everything owed.
    task drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CHR_SPACE : 8'(r);
    endfunction

    // One source line built from tokens that matter to the classifier: plain
    // code, whitespace, both comment openers, the block closer, quotes, lone
    // slashes and stars, and arbitrary bytes. Lines chain freely, so block
    // comments and strings open and close across many different contexts.
    task send_line();
        int n;
        n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
        repeat (n) begin
            case ($urandom_range(0, 11))
                0, 1, 2: send_item(ACT_CHAR, 8'($urandom_range(8'h61, 8'h7A)));
                3, 4:    send_item(ACT_CHAR, pick_space());
                5: begin
                    send_item(ACT_CHAR, CHR_SLASH);
                    send_item(ACT_CHAR, CHR_SLASH);
                end
                6: begin
                    send_item(ACT_CHAR, CHR_SLASH);
                    send_item(ACT_CHAR, CHR_STAR);
                end
                7: begin
                    send_item(ACT_CHAR, CHR_STAR);
                    send_item(ACT_CHAR, CHR_SLASH);
                end
                8:       send_item(ACT_CHAR, CHR_QUOTE);
                9:       send_item(ACT_CHAR, $urandom_range(1) ? CHR_SLASH : CHR_STAR);
                default: send_item(ACT_CHAR, 8'($urandom_range(255)));
            endcase
        end
        send_item(ACT_EOL, 8'($urandom_range(255)));
    endtask

    initial begin
        int r;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines: an empty line, a whitespace-only line, a line comment
        // with text after it, a block comment that opens, an empty line inside it,
        // a line that closes it and then has code (with the extreme bytes), a
        // comment marker hidden inside a string, the unused action code, and a
        // new file that throws away a half-built line.
        send_item(ACT_EOL,    8'h00);
        send_item(ACT_CHAR,   CHR_SPACE);
        send_item(ACT_CHAR,   CHR_TAB);
        send_item(ACT_EOL,    8'hFF);
        send_item(ACT_CHAR,   CHR_SLASH);
        send_item(ACT_CHAR,   CHR_SLASH);
        send_item(ACT_CHAR,   8'h7A);
        send_item(ACT_EOL,    8'h00);
        send_item(ACT_CHAR,   CHR_SLASH);
        send_item(ACT_CHAR,   CHR_STAR);
        send_item(ACT_EOL,    8'h00);
        send_item(ACT_EOL,    8'h00);
        send_item(ACT_CHAR,   8'hFF);
        send_item(ACT_CHAR,   CHR_STAR);
        send_item(ACT_CHAR,   CHR_SLASH);
        send_item(ACT_CHAR,   8'h00);
        send_item(ACT_EOL,    8'h00);
        send_item(ACT_CHAR,   CHR_QUOTE);
        send_item(ACT_CHAR,   CHR_SLASH);
        send_item(ACT_CHAR,   CHR_SLASH);
        send_item(ACT_CHAR,   CHR_QUOTE);
        send_item(ACT_EOL,    8'h00);
        send_item(ACT_UNUSED, 8'hA5);
        send_item(ACT_CHAR,   8'h61);
        send_item(ACT_FILE,   8'h5A);

        // Let the block empty out completely before the random traffic starts.
        drain_results();

        // Mostly well-formed lines; the rest is noise: stray characters cut off
        // by a new file, unused action codes, bare new-file items, and the
        // occasional full drain of the pipeline.
        while (sent < TOTAL_ITEMS) begin
            r = $urandom_range(99);
            if (r < 85) begin
                send_line();
            end else if (r < 90) begin
                repeat ($urandom_range(1, 4))
                    send_item(ACT_CHAR, 8'($urandom_range(255)));
                send_item(ACT_FILE, 8'($urandom_range(255)));
            end else if (r < 94) begin
                send_item(ACT_UNUSED, 8'($urandom_range(255)));
            end else if (r < 97) begin
                send_item(ACT_FILE, 8'($urandom_range(255)));
            end else begin
                drain_results();
            end
        end

        steady = 1'b0;
        drain_results();
        // Spare edges after the drain catch any stray extra result.
        repeat (8) @(posedge i_clk);

        $display("Covered %0d items plus %0d ignored codes, including %0d new-file starts.",
                 sent, ignored, file_starts);
        $display("Lines classified: %0d blank, %0d comment, %0d code, %0d whitespace-only.",
                 board.class_seen[CLS_BLANK], board.class_seen[CLS_COMMENT],
                 board.class_seen[CLS_CODE], board.class_seen[CLS_WHITE]);
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/slc_pkg.sv
rtl/core/slc_line_tracker.sv
rtl/core/slc_counters.sv
rtl/core/source_line_classifier.sv
dv/source_line_classifier_test.sv
